// ===== rtl/hbdt_pkg.sv =====
package hbdt_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned DEAD_BITS      = 16;
  localparam logic [DEAD_BITS-1:0] DEAD_TIME_RST = 16'd100;

  // opcode of an input item
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CTRL = 1'b1;

  // external motor state codes (target_state / motor_state)
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STOP = 2'd1;
  localparam logic [1:0] ST_POS  = 2'd2;
  localparam logic [1:0] ST_NEG  = 2'd3;

  // external dead-time phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_STOP = 4'b0010,
    M_POS  = 4'b0100,
    M_NEG  = 4'b1000
  } motor_e;

  typedef enum logic [3:0] {
    D_IDLE  = 4'b0001,
    D_START = 4'b0010,
    D_RUN   = 4'b0100,
    D_DONE  = 4'b1000
  } dead_e;

  typedef enum logic [1:0] {
    DR_OFF = 2'd0,
    DR_POS = 2'd1,
    DR_NEG = 2'd2
  } drive_e;

  typedef struct packed {
    logic       opcode;
    logic [1:0] target_state;
    logic       linear_enable;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           motor_state;
    logic [1:0]           bridge_drive;
    logic [1:0]           dead_phase;
    logic [DEAD_BITS-1:0] ticks_left;
    logic                 timer_expired;
  } out_item_t;

  function automatic logic [1:0] motor_code(motor_e s);
    logic [1:0] c;
    case (s)
      M_IDLE:  c = ST_IDLE;
      M_STOP:  c = ST_STOP;
      M_POS:   c = ST_POS;
      M_NEG:   c = ST_NEG;
      default: c = ST_IDLE;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] dead_code(dead_e p);
    logic [1:0] c;
    case (p)
      D_IDLE:  c = PH_IDLE;
      D_START: c = PH_START;
      D_RUN:   c = PH_RUN;
      D_DONE:  c = PH_DONE;
      default: c = PH_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/hbridge_direction_dead_time_fsm_top.sv =====
// Each input transfer writes its result into the output register at the following clock edge.
// One item per cycle while the output is not stalled; the whole state update is a single pass of
// logic (one counter decrement, one compare) into the state and result registers.
// Reset (async, active low): motor idle, drive off, dead-time phase idle,
// countdown zero, expired flag low, dead time 100 ticks, no result pending.
module hbridge_direction_dead_time_fsm_top
  import hbdt_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [DEAD_BITS-1:0] cfg_data_i
);

  // Working width wide enough for both the dead-time register and the counter.
  localparam int unsigned WIDE_BITS = (COUNT_BITS > DEAD_BITS) ? COUNT_BITS : DEAD_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [DEAD_BITS-1:0]  dead_time_q;
  motor_e                state_q, state_d;
  drive_e                drive_q, drive_d;
  dead_e                 phase_q, phase_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  exp_q, exp_d;
  logic                  out_valid_q;
  out_item_t             out_q, out_d;

  logic                  in_xfer;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic [COUNT_BITS-1:0] load_val;
  logic [WIDE_BITS-1:0]  dead_wide;
  logic [WIDE_BITS-1:0]  cnt_wide;

  // Config is always taken; the user must write it only while the block is idle (not enforced here).
  assign cfg_ready_o = 1'b1;

  // Output register parts the two sides: take a new item whenever the held
  // result leaves in the same cycle or there is none.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Dead time saturates to the counter range when the counter is narrow.
  assign dead_wide = WIDE_BITS'(dead_time_q);
  assign load_val  = (dead_wide > WIDE_BITS'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(dead_wide);
  assign cnt_dec   = cnt_q - COUNT_BITS'(1);

  always_comb begin
    logic [1:0] tgt;
    tgt     = in_data_i.target_state;
    state_d = state_q;
    drive_d = drive_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    exp_d   = exp_q;

    if (in_data_i.opcode == OP_TICK) begin
      // millisecond tick: count down, flag on reaching zero
      if (cnt_q != '0) begin
        cnt_d = cnt_dec;
        exp_d = (cnt_dec == '0);
      end
    end else begin
      // disabled: force stop, drive off, restart dead time
      if (!in_data_i.linear_enable) begin
        tgt     = ST_STOP;
        drive_d = DR_OFF;
        state_d = M_STOP;
        phase_d = D_START;
      end
      case (state_d)
        M_IDLE: begin
          if (tgt != ST_IDLE) begin
            drive_d = DR_OFF;
            state_d = M_STOP;
            phase_d = D_START;
          end
        end
        M_STOP: begin
          // dead-time sub-machine; zero dead time completes in this step
          if (phase_d == D_IDLE || phase_d == D_START) begin
            if (dead_time_q == '0) begin
              exp_d = 1'b1;
              cnt_d = '0;
            end else begin
              exp_d = 1'b0;
              cnt_d = load_val;
            end
            phase_d = D_RUN;
          end
          if (phase_d == D_RUN && exp_d) begin
            cnt_d   = '0;
            exp_d   = 1'b0;
            phase_d = D_DONE;
          end
          if (tgt == ST_IDLE) begin
            drive_d = DR_OFF;
            state_d = M_IDLE;
          end else if (tgt == ST_POS && phase_d == D_DONE) begin
            drive_d = DR_POS;
            state_d = M_POS;
          end else if (tgt == ST_NEG && phase_d == D_DONE) begin
            drive_d = DR_NEG;
            state_d = M_NEG;
          end
        end
        M_POS: begin
          if (tgt == ST_IDLE) begin
            drive_d = DR_OFF;
            state_d = M_IDLE;
            phase_d = D_START;
          end else if (tgt != ST_POS) begin
            drive_d = DR_OFF;
            state_d = M_STOP;
            phase_d = D_START;
          end
        end
        default: begin
          // negative drive
          if (tgt == ST_IDLE) begin
            drive_d = DR_OFF;
            state_d = M_IDLE;
            phase_d = D_START;
          end else if (tgt != ST_NEG) begin
            drive_d = DR_OFF;
            state_d = M_STOP;
            phase_d = D_START;
          end
        end
      endcase
    end
  end

  // Result shows the state after the item; ticks are the low bits of the count.
  assign cnt_wide = WIDE_BITS'(cnt_d);

  always_comb begin
    out_d.motor_state   = motor_code(state_d);
    out_d.bridge_drive  = drive_d;
    out_d.dead_phase    = dead_code(phase_d);
    out_d.ticks_left    = cnt_wide[DEAD_BITS-1:0];
    out_d.timer_expired = exp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_time_q <= DEAD_TIME_RST;
      state_q     <= M_IDLE;
      drive_q     <= DR_OFF;
      phase_q     <= D_IDLE;
      cnt_q       <= '0;
      exp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        dead_time_q <= cfg_data_i;
      end
      if (in_xfer) begin
        state_q <= state_d;
        drive_q <= drive_d;
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        exp_q   <= exp_d;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

  // bridge is driven only in the matching motion state
  a_drive_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drive_q == DR_POS) |-> (state_q == M_POS))
    else $error("positive drive outside positive state");

  a_drive_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drive_q == DR_NEG) |-> (state_q == M_NEG))
    else $error("negative drive outside negative state");

  // a completed dead time leaves the timer cleared
  a_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == D_DONE) |-> (cnt_q == '0 && !exp_q))
    else $error("dead time complete with timer not cleared");

  // a stalled result blocks new transfers
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while result stalled");

  // timer state moves only on an input transfer
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> ($stable(cnt_q) && $stable(exp_q)))
    else $error("timer changed without a transfer");

endmodule

// ===== dv/hbridge_direction_dead_time_fsm_top_tb.sv =====
module hbridge_direction_dead_time_fsm_top_tb;
  import hbdt_pkg::*;

  // Counter width of the instance; the predictor clamps loads to it.
  localparam int unsigned CNT_W = COUNT_BITS_DEF;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 1;

  localparam int unsigned PHASE_ITEMS     = 270;    // random items per idle phase
  localparam int unsigned HOLD_OFF_CYCLES = 300;    // long receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT  = 20000;  // quiet cycles before giving up
  localparam int unsigned MAX_PRINTS      = 40;

  // ---------------------------------------------------------------------------
  // DUT hookup. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [DEAD_BITS-1:0] cfg_data_i  = '0;

  hbridge_direction_dead_time_fsm_top #(
    .COUNT_BITS(CNT_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  in_item_t  pending_items[$];     // stimulus waiting for the driver
  out_item_t expected_results[$];  // predicted results, oldest first

  int unsigned send_idle_pct = 0;  // chance per cycle that the sender idles
  int unsigned stall_pct     = 0;  // chance per cycle that the receiver stalls
  int unsigned hold_off_seq  = 0;  // bumped by the sequencer to request a hold-off
  int unsigned hold_off_seen = 0;
  int unsigned hold_left     = 0;

  int unsigned errors       = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes   = 0;
  int unsigned push_count   = 0;
  int unsigned quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Motor controller predictor: own copy of the state and the dead time.
  // ---------------------------------------------------------------------------
  logic [DEAD_BITS-1:0] dead_time_cfg = DEAD_TIME_RST;
  logic [1:0]           mtr_state     = ST_IDLE;
  drive_e               drv_cmd       = DR_OFF;
  logic [1:0]           dt_phase      = PH_IDLE;
  logic [CNT_W-1:0]     dt_count      = '0;
  logic                 dt_expired    = 1'b0;

  // Drive off, move to the given state and restart the dead time.
  function automatic void enter_stop(logic [1:0] nxt);
    drv_cmd   = DR_OFF;
    mtr_state = nxt;
    dt_phase  = PH_START;
  endfunction

  function automatic out_item_t predict_motor(in_item_t it);
    out_item_t  r;
    logic [1:0] tgt;
    tgt = it.target_state;
    if (it.opcode == OP_TICK) begin
      // target and enable are don't-care on a tick
      if (dt_count != '0) begin
        dt_count   = dt_count - 1'b1;
        dt_expired = (dt_count == '0);
      end
    end else begin
      if (!it.linear_enable) begin
        tgt = ST_STOP;
        enter_stop(ST_STOP);
      end
      case (mtr_state)
        ST_IDLE: begin
          if (tgt != ST_IDLE) enter_stop(ST_STOP);
        end
        ST_STOP: begin
          // dead-time sub-machine only runs while stopped
          if (dt_phase == PH_IDLE || dt_phase == PH_START) begin
            if (dead_time_cfg == '0) begin
              dt_expired = 1'b1;
              dt_count   = '0;
            end else begin
              if (64'(dead_time_cfg) > CNT_MAX) dt_count = '1;
              else dt_count = CNT_W'(dead_time_cfg);
              dt_expired = 1'b0;
            end
            dt_phase = PH_RUN;
          end
          if (dt_phase == PH_RUN && dt_expired) begin
            dt_count   = '0;
            dt_expired = 1'b0;
            dt_phase   = PH_DONE;
          end
          if (tgt == ST_IDLE) begin
            drv_cmd   = DR_OFF;
            mtr_state = ST_IDLE;
          end else if (tgt == ST_POS && dt_phase == PH_DONE) begin
            drv_cmd   = DR_POS;
            mtr_state = ST_POS;
          end else if (tgt == ST_NEG && dt_phase == PH_DONE) begin
            drv_cmd   = DR_NEG;
            mtr_state = ST_NEG;
          end
        end
        ST_POS: begin
          if (tgt == ST_IDLE) enter_stop(ST_IDLE);
          else if (tgt != ST_POS) enter_stop(ST_STOP);
        end
        default: begin
          if (tgt == ST_IDLE) enter_stop(ST_IDLE);
          else if (tgt != ST_NEG) enter_stop(ST_STOP);
        end
      endcase
    end
    r.motor_state   = mtr_state;
    r.bridge_drive  = drv_cmd;
    r.dead_phase    = dt_phase;
    r.ticks_left    = DEAD_BITS'(dt_count);
    r.timer_expired = dt_expired;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: pops pending items, holds valid and payload until transfer.
  // Every accepted item is run through the predictor right here.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(predict_motor(in_data_i));
        items_sent++;
      end
      // slot is free when nothing is offered or the offer just transferred
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver ready: random stalls, plus a long hold-off on request so the
  // output register fills and the block back-pressures its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off_seq != hold_off_seen) begin
      hold_off_seen = hold_off_seq;
      hold_left     = HOLD_OFF_CYCLES;
      out_ready_i   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every result transfer is checked against the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < MAX_PRINTS)
      $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    errors++;
  endtask

  out_item_t want_res;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(out_data_o), '0);
      end else begin
        want_res = expected_results.pop_front();
        if (out_data_o.motor_state !== want_res.motor_state)
          report_mismatch("motor_state", 32'(out_data_o.motor_state),
                          32'(want_res.motor_state));
        if (out_data_o.bridge_drive !== want_res.bridge_drive)
          report_mismatch("bridge_drive", 32'(out_data_o.bridge_drive),
                          32'(want_res.bridge_drive));
        if (out_data_o.dead_phase !== want_res.dead_phase)
          report_mismatch("dead_phase", 32'(out_data_o.dead_phase),
                          32'(want_res.dead_phase));
        if (out_data_o.ticks_left !== want_res.ticks_left)
          report_mismatch("ticks_left", 32'(out_data_o.ticks_left),
                          32'(want_res.ticks_left));
        if (out_data_o.timer_expired !== want_res.timer_expired)
          report_mismatch("timer_expired", 32'(out_data_o.timer_expired),
                          32'(want_res.timer_expired));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any transfer on any channel counts as progress.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_item(logic op, logic [1:0] tgt, logic en);
    in_item_t it;
    it.opcode        = op;
    it.target_state  = tgt;
    it.linear_enable = en;
    pending_items.push_back(it);
    push_count++;
  endtask

  // tick with random don't-care bits
  task automatic add_tick();
    add_item(OP_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  // Mostly well-formed moves (request, arm the timer, wait it out, go),
  // the rest single random items and short waits that break the sequence.
  task automatic push_random_burst();
    logic [1:0]  tgt;
    int unsigned n;
    if ($urandom_range(99) < 25) begin
      add_item(1'($urandom_range(1)), 2'($urandom_range(3)), $urandom_range(99) < 85);
    end else begin
      tgt = 2'($urandom_range(3));
      add_item(OP_CTRL, tgt, 1'b1);
      add_item(OP_CTRL, tgt, 1'b1);
      if (dead_time_cfg > 20) n = $urandom_range(20);
      else n = dead_time_cfg + $urandom_range(1);
      if (n != 0 && $urandom_range(9) == 0) n = $urandom_range(n - 1);
      repeat (n) add_tick();
      repeat ($urandom_range(1, 2)) add_item(OP_CTRL, tgt, 1'b1);
    end
  endtask

  // Wait until every item went in and every result came back out.
  task automatic drain_all();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Dead-time write; only called with the block idle, on a clock edge.
  task automatic write_dead_time(logic [DEAD_BITS-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    dead_time_cfg = v;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  int unsigned send_pcts[4]  = '{0, 83, 0, 22};
  int unsigned stall_pcts[4] = '{0, 0, 83, 22};

  initial begin
    logic [DEAD_BITS-1:0] dt_val;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset dead time of 100: tick on an empty timer, same-state
    // request, start from idle, timer load, one tick, disable while counting
    // (restarts the dead time), back to idle.
    add_tick();
    add_item(OP_CTRL, ST_IDLE, 1'b1);
    add_item(OP_CTRL, ST_POS,  1'b1);
    add_item(OP_CTRL, ST_POS,  1'b1);
    add_tick();
    add_item(OP_CTRL, ST_NEG,  1'b0);
    add_item(OP_CTRL, ST_IDLE, 1'b1);
    drain_all();

    // Zero dead time completes in the step that starts it; reversal,
    // same-state hold, drive to idle, plain stop, disable from idle.
    write_dead_time('0);
    add_item(OP_CTRL, ST_NEG,  1'b1);
    add_item(OP_CTRL, ST_NEG,  1'b1);
    add_item(OP_CTRL, ST_POS,  1'b1);
    add_item(OP_CTRL, ST_POS,  1'b1);
    add_item(OP_CTRL, ST_POS,  1'b1);
    add_item(OP_CTRL, ST_IDLE, 1'b1);
    add_item(OP_CTRL, ST_STOP, 1'b1);
    add_item(OP_CTRL, ST_STOP, 1'b1);
    add_item(OP_CTRL, ST_IDLE, 1'b1);
    add_item(OP_CTRL, ST_NEG,  1'b0);
    drain_all();

    // Short dead time: countdown to expiry, tick at zero, then drive.
    write_dead_time(16'd2);
    add_item(OP_CTRL, ST_POS,  1'b1);
    add_item(OP_CTRL, ST_NEG,  1'b1);
    add_item(OP_CTRL, ST_NEG,  1'b1);
    add_tick();
    add_tick();
    add_tick();
    add_item(OP_CTRL, ST_NEG,  1'b1);
    add_item(OP_CTRL, ST_IDLE, 1'b1);
    drain_all();

    // Random phases, each with its own dead time and idling pattern.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       dt_val = 16'd5;
        1:       dt_val = '1;  // largest dead time, never runs out here
        2:       dt_val = 16'd1;
        default: dt_val = DEAD_BITS'($urandom_range(12));
      endcase
      write_dead_time(dt_val);
      send_idle_pct = send_pcts[p];
      stall_pct     = stall_pcts[p];
      push_count    = 0;
      while (push_count < PHASE_ITEMS) push_random_burst();
      // receiver holds off while the sender keeps offering
      if (p == 0) hold_off_seq++;
      drain_all();
    end

    repeat (10) @(posedge clk_i);
    $display("covered %0d input transfers and %0d checked results over %0d dead-time writes",
             items_sent, results_seen, cfg_writes);
    $display("dead times 0..65535, idling none/sender/receiver/both, long receiver hold-off");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
